FILE: design/pba_pkg.sv
// Shared types, constants and codes for the page bitmap allocator.
`timescale 1ns / 1ps

package pba_pkg;

  // Default geometry of the managed region.
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int PAGE_COUNT_DEF = 4096;

  // Used map is stored as words of this many page bits.
  localparam int WORD_BITS  = 16;
  localparam int WORD_SHIFT = 4;

  // Common width for page-count arithmetic (covers 33-bit sums).
  localparam int CMPW = 34;

  // Configuration register.
  localparam int          SSP_W      = 12;
  localparam logic [11:0] SSP_RESET  = 12'd2048;
  localparam int          APB_AW     = 2;
  localparam int          APB_DW     = 32;
  localparam int          REG_SSP    = 0;

  // Stream payload widths.
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 1;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_FIXED = 2'd1,
    OP_UNMAP = 2'd2,
    OP_NONE  = 2'd3
  } pba_op_t;

  // What the decoded item turns into.
  typedef enum logic [2:0] {
    K_FAIL,
    K_ZERO,
    K_SCAN,
    K_SET,
    K_CLR
  } pba_kind_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic fail;
    logic zero_ok;
    logic scan_init;
    logic scan_rd;
    logic scan_step;
    logic scan_found;
    logic mark_init;
    logic mark_rd;
    logic mark_wr;
    logic emit;
  } pba_cmd_t;

  typedef struct packed {
    pba_kind_t kind;
    logic      mark_empty;
    logic      scan_hit;
    logic      scan_end;
    logic      word_end;
    logic      mark_last;
    logic      clr_last;
    logic      out_free;
  } pba_stat_t;

endpackage

FILE: design/pba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/pba_dp.sv
// Datapath: item decode, scan and mark registers, used-map RAM, result register.
`timescale 1ns / 1ps

module pba_dp #(
  parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF,
  parameter int PAGE_COUNT = pba_pkg::PAGE_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pba_pkg::pba_cmd_t        cmd,
  output pba_pkg::pba_stat_t       stat,
  input  pba_pkg::pba_op_t         in_op,
  input  logic [31:0]              in_address,
  input  logic [31:0]              in_length,
  input  logic                     in_file_backed,
  input  logic                     in_shared_or_anon,
  input  logic [pba_pkg::SSP_W-1:0] search_start_page,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_status,
  output logic [31:0]              out_mapped_address
);
  import pba_pkg::*;

  localparam int SHIFT = $clog2(PAGE_BYTES);
  localparam int PW    = $clog2(PAGE_COUNT + 1);
  localparam int DEPTH = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Latched item
  pba_op_t     op_r;
  logic [31:0] addr_r;
  logic [31:0] len_r;
  logic        fb_r;
  logic        sa_r;

  // Scan / mark state
  logic [PW-1:0] p;
  logic [PW-1:0] run;
  logic [PW-1:0] pages_r;
  logic [PW-1:0] mfirst;
  logic [PW-1:0] mend;
  logic          mset;
  logic [AW-1:0] widx;
  logic          res_status;
  logic [31:0]   res_addr;

  // Decode
  logic [32:0]     sum_ceil;
  logic [32:0]     end_sum;
  logic [CMPW-1:0] pages_ceil;
  logic [CMPW-1:0] pages_floor;
  logic [CMPW-1:0] addr_pg;
  logic [CMPW-1:0] start_c;
  logic [CMPW-1:0] end_pg;
  logic [CMPW-1:0] pn_c;
  logic [CMPW-1:0] mk_count;
  logic [CMPW-1:0] mk_sum;
  logic [CMPW-1:0] mk_end;
  logic            aligned;
  logic            bad_file;
  logic [63:0]     start_wide;
  logic [63:0]     found_wide;
  logic [PW-1:0]   found;
  logic            cur_bit;

  // RAM
  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] mark_data;
  logic [CMPW-1:0]      pg_i;

  always_comb begin
    sum_ceil    = {1'b0, len_r} + 33'(PAGE_BYTES - 1);
    end_sum     = {1'b0, addr_r} + {1'b0, len_r};
    pages_ceil  = CMPW'(sum_ceil >> SHIFT);
    pages_floor = CMPW'(len_r >> SHIFT);
    addr_pg     = CMPW'(addr_r >> SHIFT);
    start_c     = (addr_r == 32'd0) ? CMPW'(search_start_page) : addr_pg;
    end_pg      = CMPW'(end_sum >> SHIFT);
    pn_c        = CMPW'(PAGE_COUNT);
    aligned     = (addr_r[SHIFT-1:0] == '0);
    bad_file    = fb_r && sa_r;
    mk_count    = (op_r == OP_FIXED) ? pages_floor : pages_ceil;
    mk_sum      = addr_pg + mk_count;
    mk_end      = (mk_sum < pn_c) ? mk_sum : pn_c;
    start_wide  = 64'(start_c) << SHIFT;
    found       = p + PW'(1) - pages_r;
    found_wide  = 64'(found) << SHIFT;
    cur_bit     = ram_rdata[p[WORD_SHIFT-1:0]];
  end

  always_comb begin
    stat.kind = K_FAIL;
    case (op_r)
      OP_MAP: begin
        if (pages_ceil >= pn_c || start_c >= pn_c - pages_ceil || bad_file) begin
          stat.kind = K_FAIL;
        end else if (pages_ceil == '0) begin
          stat.kind = K_ZERO;
        end else begin
          stat.kind = K_SCAN;
        end
      end
      OP_FIXED: begin
        // region end must stay free; the page-granular compare is exact
        if (!aligned || end_pg >= pn_c || bad_file) begin
          stat.kind = K_FAIL;
        end else begin
          stat.kind = K_SET;
        end
      end
      OP_UNMAP: begin
        stat.kind = aligned ? K_CLR : K_FAIL;
      end
      default: stat.kind = K_FAIL;
    endcase
    stat.mark_empty = (addr_pg >= mk_end);
    stat.scan_hit   = !cur_bit && (run + PW'(1) == pages_r);
    stat.scan_end   = (p == PW'(PAGE_COUNT - 2));
    stat.word_end   = &p[WORD_SHIFT-1:0];
    stat.mark_last  = (widx == AW'((mend - PW'(1)) >> WORD_SHIFT));
    stat.clr_last   = (widx == AW'(DEPTH - 1));
    stat.out_free   = !out_valid || out_ready;
  end

  // Read-modify-write data for one map word
  always_comb begin
    pg_i = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      pg_i = (CMPW'(widx) << WORD_SHIFT) + CMPW'(i);
      if (pg_i >= CMPW'(mfirst) && pg_i < CMPW'(mend)) begin
        mark_data[i] = mset;
      end else begin
        mark_data[i] = ram_rdata[i];
      end
    end
  end

  assign ram_we    = cmd.clr_wr || cmd.mark_wr;
  assign ram_wdata = cmd.clr_wr ? '0 : mark_data;
  assign ram_re    = cmd.scan_rd || cmd.mark_rd;
  assign ram_raddr = cmd.scan_rd ? AW'(p >> WORD_SHIFT) : widx;

  pba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      addr_r <= in_address;
      len_r  <= in_length;
      fb_r   <= in_file_backed;
      sa_r   <= in_shared_or_anon;
    end
    if (cmd.scan_init) begin
      p       <= PW'(start_c);
      run     <= '0;
      pages_r <= PW'(pages_ceil);
    end
    if (cmd.scan_step) begin
      run <= cur_bit ? '0 : run + PW'(1);
      p   <= p + PW'(1);
    end
    if (cmd.fail) begin
      res_status <= 1'b1;
      res_addr   <= '0;
    end
    if (cmd.zero_ok) begin
      res_status <= 1'b0;
      res_addr   <= start_wide[31:0];
    end
    if (cmd.mark_init) begin
      mfirst     <= PW'(addr_pg);
      mend       <= PW'(mk_end);
      mset       <= (op_r == OP_FIXED);
      res_status <= 1'b0;
      res_addr   <= (op_r == OP_FIXED) ? addr_r : 32'd0;
    end
    if (cmd.scan_found) begin
      mfirst     <= found;
      mend       <= p + PW'(1);
      mset       <= 1'b1;
      res_status <= 1'b0;
      res_addr   <= found_wide[31:0];
    end
    if (cmd.emit) begin
      out_status         <= res_status;
      out_mapped_address <= res_addr;
    end
    if (rst) begin
      widx <= '0;
    end else if (cmd.clr_wr || cmd.mark_wr) begin
      widx <= widx + AW'(1);
    end else if (cmd.mark_init) begin
      widx <= AW'(addr_pg >> WORD_SHIFT);
    end else if (cmd.scan_found) begin
      widx <= AW'(found >> WORD_SHIFT);
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_mark_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mark_wr |-> (mfirst < mend))
    else $error("mark write with an empty page range");

  a_found_in_region: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_found |-> (CMPW'(p) + CMPW'(1) < CMPW'(PAGE_COUNT)))
    else $error("scan found a run touching the last page");

endmodule

FILE: design/pba_ctrl.sv
// Controller: sequences clearing, decode, scan, mark and result hand-off.
`timescale 1ns / 1ps

module pba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pba_pkg::pba_stat_t stat,
  output pba_pkg::pba_cmd_t  cmd
);
  import pba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_BIT,
    S_MARK_RD,
    S_MARK_WR,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.kind)
          K_ZERO: begin
            cmd.zero_ok = 1'b1;
            state_next  = S_FINISH;
          end
          K_SCAN: begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN_RD;
          end
          K_SET, K_CLR: begin
            cmd.mark_init = 1'b1;
            state_next    = stat.mark_empty ? S_FINISH : S_MARK_RD;
          end
          default: begin
            cmd.fail   = 1'b1;
            state_next = S_FINISH;
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_BIT;
      end
      S_SCAN_BIT: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          cmd.scan_found = 1'b1;
          state_next     = S_MARK_RD;
        end else if (stat.scan_end) begin
          cmd.fail   = 1'b1;
          state_next = S_FINISH;
        end else if (stat.word_end) begin
          state_next = S_SCAN_RD;
        end
      end
      S_MARK_RD: begin
        cmd.mark_rd = 1'b1;
        state_next  = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        state_next  = stat.mark_last ? S_FINISH : S_MARK_RD;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/page_bitmap_allocator.sv
// Top level of the first-fit page bitmap allocator.
`timescale 1ns / 1ps

// First-fit page allocator over a one-bit-per-page used map held in a RAM of
// 16-page words. Commands: map anywhere (first-fit search for
// ceil(length/PAGE_BYTES) free pages from the hint page, or from
// search_start_page when the hint is zero), map fixed (marks
// floor(length/PAGE_BYTES) pages, must be aligned and stop short of the last
// page of the region) and unmap (clears ceil(length/PAGE_BYTES) pages, pages
// past the region ignored). One item is worked at a time, one result per item.
// Each item is accepted, decoded and its result handed off; a search examines
// the pages one at a time and reads each 16-page word as it reaches it, and
// marking or clearing reads and then writes each map word touched (through
// the single RAM port pair).
// The hand-off waits while the previous result is still held downstream.
// After reset a clearing pass writes every map word to zero, one word a cycle
// (PAGE_COUNT/16 words, 256 at the defaults); s_tready stays low meanwhile.
// A finished result sits in an output register, so the next item is taken
// while it waits. PAGE_BYTES must be a power of two.
module page_bitmap_allocator #(
  parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF,
  parameter int PAGE_COUNT = pba_pkg::PAGE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [31:0] address, [63:32] length, [64] file_backed, [65] shared_or_anon
  input  logic [pba_pkg::IN_DATA_W-1:0]   s_tdata,
  // [1:0] cmd
  input  logic [pba_pkg::IN_USER_W-1:0]   s_tuser,
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] mapped_address
  output logic [pba_pkg::OUT_DATA_W-1:0]  m_tdata,
  // [0] status
  output logic [pba_pkg::OUT_USER_W-1:0]  m_tuser,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pba_pkg::APB_AW-1:0]      paddr,
  input  logic [pba_pkg::APB_DW-1:0]      pwdata,
  output logic [pba_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);
  import pba_pkg::*;

  logic [SSP_W-1:0] search_start_page;
  logic             ssp_sel;
  pba_cmd_t         cmd;
  pba_stat_t        stat;

  // Register file: a single register at byte address 0.
  assign pready  = 1'b1;
  assign ssp_sel = (paddr == APB_AW'(REG_SSP * 4));
  assign prdata  = ssp_sel ? APB_DW'(search_start_page) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_start_page <= SSP_RESET;
    end else if (psel && penable && pwrite && pready && ssp_sel) begin
      search_start_page <= pwdata[SSP_W-1:0];
    end
  end

  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pba_dp #(
    .PAGE_BYTES (PAGE_BYTES),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .in_op              (pba_op_t'(s_tuser)),
    .in_address         (s_tdata[31:0]),
    .in_length          (s_tdata[63:32]),
    .in_file_backed     (s_tdata[64]),
    .in_shared_or_anon  (s_tdata[65]),
    .search_start_page  (search_start_page),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .out_status         (m_tuser[0]),
    .out_mapped_address (m_tdata)
  );

  // one item in flight: acceptance drops ready until the item is done
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while one is in flight");

endmodule
